/* rtl/lfq_pkg.sv */
// ----------------------------------------------------------------------------
// lfq_pkg
// Shared types, sizes, codes and helper functions of the linked FIFO queue
// with its node pool.
// ----------------------------------------------------------------------------
package lfq_pkg;

    localparam int POOL_NODES = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int NODE_W     = $clog2(POOL_NODES);

    typedef logic [NODE_W-1:0]     t_node;
    typedef logic [DATA_WIDTH-1:0] t_data;

    localparam t_node LAST_NODE = t_node'(POOL_NODES - 1);
    localparam t_node HEAD_NODE = t_node'(0);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_POOL_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic  we;
        t_node waddr;
        t_node wdata;
        t_node raddr;
    } t_link_port;

    typedef struct packed {
        logic  we;
        t_node waddr;
        t_data wdata;
        t_node raddr;
    } t_data_port;

    function automatic t_data to_data(input logic [31:0] v);
        logic [63:0] w;
        w = {32'h0, v};
        return w[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] to_word(input t_data d);
        logic signed [63:0] w;
        w = 64'(signed'(d));
        return w[31:0];
    endfunction

endpackage

/* rtl/lfq_ram.sv */
// ----------------------------------------------------------------------------
// lfq_ram
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module lfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/lfq_ctrl.sv */
// ----------------------------------------------------------------------------
// lfq_ctrl
// Sequencer of the queue: holds the free list head, the first and rear
// nodes, runs the link initialization pass and the push and pop steps.
// ----------------------------------------------------------------------------
module lfq_ctrl
    import lfq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [31:0] i_value,
    output t_link_port  o_link_port,
    input  t_node       i_link_rdata,
    output t_data_port  o_data_port,
    input  t_data       i_data_rdata,
    output logic        o_done,
    output t_status     o_status,
    output logic        o_is_empty,
    output logic [31:0] o_front_value
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUSH,
        S_POP_LINK,
        S_POP_DATA
    } t_state;

    t_state r_state;
    t_node  r_init_idx;
    logic   r_free_v;
    t_node  r_free_idx;
    logic   r_first_v;
    t_node  r_first_idx;
    t_node  r_rear;
    t_data  r_value;
    t_data  r_front;

    t_node  free_link;
    logic   accept;
    logic   pop_last;

    assign free_link = r_free_v ? r_free_idx : HEAD_NODE;
    assign accept    = start && (r_state == S_IDLE);
    assign pop_last  = accept && (i_opcode == OP_POP) && r_first_v && (r_first_idx == r_rear);
    assign busy      = (r_state != S_IDLE);

    always_comb begin
        o_link_port.we    = 1'b0;
        o_link_port.waddr = r_first_idx;
        o_link_port.wdata = free_link;
        o_link_port.raddr = (i_opcode == OP_PUSH) ? r_free_idx : r_first_idx;
        o_data_port.we    = 1'b0;
        o_data_port.waddr = r_free_idx;
        o_data_port.wdata = r_value;
        o_data_port.raddr = i_link_rdata;
        unique case (r_state)
            S_INIT: begin
                o_link_port.we    = 1'b1;
                o_link_port.waddr = r_init_idx;
                o_link_port.wdata = (r_init_idx == LAST_NODE) ? HEAD_NODE
                                                               : r_init_idx + t_node'(1);
            end
            S_IDLE: begin
                o_link_port.we = pop_last;
            end
            S_PUSH: begin
                o_link_port.we    = (r_rear != HEAD_NODE);
                o_link_port.waddr = r_rear;
                o_link_port.wdata = r_free_idx;
                o_data_port.we    = 1'b1;
            end
            S_POP_LINK: begin
                o_link_port.we = 1'b1;
            end
            S_POP_DATA: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_idx  <= HEAD_NODE;
            r_free_v    <= 1'b1;
            r_free_idx  <= t_node'(1);
            r_first_v   <= 1'b0;
            r_first_idx <= HEAD_NODE;
            r_rear      <= HEAD_NODE;
            o_done      <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_init_idx <= r_init_idx + t_node'(1);
                    if (r_init_idx == LAST_NODE) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_value <= to_data(i_value);
                        if (i_opcode == OP_PUSH) begin
                            if (r_free_v) begin
                                r_state <= S_PUSH;
                            end else begin
                                o_done        <= 1'b1;
                                o_status      <= ST_POOL_FULL;
                                o_is_empty    <= !r_first_v;
                                o_front_value <= r_first_v ? to_word(r_front) : 32'h0;
                            end
                        end else if (!r_first_v) begin
                            o_done        <= 1'b1;
                            o_status      <= ST_POP_EMPTY;
                            o_is_empty    <= 1'b1;
                            o_front_value <= 32'h0;
                        end else if (pop_last) begin
                            r_free_v      <= 1'b1;
                            r_free_idx    <= r_first_idx;
                            r_first_v     <= 1'b0;
                            r_rear        <= HEAD_NODE;
                            o_done        <= 1'b1;
                            o_status      <= ST_OK;
                            o_is_empty    <= 1'b1;
                            o_front_value <= 32'h0;
                        end else begin
                            r_state <= S_POP_LINK;
                        end
                    end
                end
                S_PUSH: begin
                    r_free_v   <= (i_link_rdata != HEAD_NODE);
                    r_free_idx <= i_link_rdata;
                    r_rear     <= r_free_idx;
                    r_first_v  <= 1'b1;
                    o_done     <= 1'b1;
                    o_status   <= ST_OK;
                    o_is_empty <= 1'b0;
                    if (!r_first_v) begin
                        r_first_idx   <= r_free_idx;
                        r_front       <= r_value;
                        o_front_value <= to_word(r_value);
                    end else begin
                        o_front_value <= to_word(r_front);
                    end
                    r_state <= S_IDLE;
                end
                S_POP_LINK: begin
                    r_free_v    <= 1'b1;
                    r_free_idx  <= r_first_idx;
                    r_first_idx <= i_link_rdata;
                    r_state     <= S_POP_DATA;
                end
                S_POP_DATA: begin
                    r_front       <= i_data_rdata;
                    o_done        <= 1'b1;
                    o_status      <= ST_OK;
                    o_is_empty    <= 1'b0;
                    o_front_value <= to_word(i_data_rdata);
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/linked_fifo_with_node_pool_unit.sv */
// ----------------------------------------------------------------------------
// linked_fifo_with_node_pool_unit
// FIFO queue kept as a singly linked list in a fixed node pool, with a
// last-in-first-out free list and a permanent dummy head at node 0.
//
// Channel   Direction  Handshake          Payload
// command   in         start, busy        i_opcode, i_value
// result    out        o_done strobe      o_status, o_is_empty, o_front_value
//
// A transaction is taken when start is high and busy is low; its result is
// registered onto the strobe in its last working state. Rejected commands
// and the pop of the last entry end in the accepting idle state; a push
// goes on through S_PUSH, any other pop through S_POP_LINK and S_POP_DATA,
// paced by the link and data memory reads. After reset the link memory is
// initialized in a pass with busy high. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module linked_fifo_with_node_pool_unit
    import lfq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_opcode,
    input  logic signed [31:0] i_value,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic               o_is_empty,
    output logic signed [31:0] o_front_value
);

    t_link_port link_port;
    t_data_port data_port;
    t_node      link_rdata;
    t_data      data_rdata;
    t_status    status;
    logic [31:0] front_value;

    lfq_ram #(
        .WIDTH(NODE_W),
        .DEPTH(POOL_NODES)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_port.we),
        .i_waddr(link_port.waddr),
        .i_wdata(link_port.wdata),
        .i_raddr(link_port.raddr),
        .o_rdata(link_rdata)
    );

    lfq_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(POOL_NODES)
    ) u_data_ram (
        .i_clk  (i_clk),
        .i_we   (data_port.we),
        .i_waddr(data_port.waddr),
        .i_wdata(data_port.wdata),
        .i_raddr(data_port.raddr),
        .o_rdata(data_rdata)
    );

    lfq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .o_link_port  (link_port),
        .i_link_rdata (link_rdata),
        .o_data_port  (data_port),
        .i_data_rdata (data_rdata),
        .o_done       (o_done),
        .o_status     (status),
        .o_is_empty   (o_is_empty),
        .o_front_value(front_value)
    );

    assign o_status      = status;
    assign o_front_value = signed'(front_value);

endmodule
